@@ hdl/bqe_pkg.sv @@
package bqe_pkg;

   // field widths
   localparam int IDX_W      = 12;
   localparam int OFS_W      = 21;
   localparam int SIZE_W     = 24;
   localparam int POS_W      = 32;
   localparam int COMP_W     = 16;
   localparam int AXIS_W     = 3 * COMP_W;
   localparam int GROUP_W    = 8;
   localparam int VTX_W      = 14;
   localparam int TEX_W      = 16;
   localparam int CORNER_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   // atlas cell extent, 51/256 in Q0.16
   localparam logic [TEX_W-1:0] CELL_Q16 = 16'd13056;

   localparam int GROUP_COUNT = 5;
   localparam int FRAME_COUNT = 25;
   localparam logic [GROUP_W-1:0] GROUP_LAST = 8'd4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAMERA_X    = 3'd0,
      CSR_CAMERA_Y    = 3'd1,
      CSR_CAMERA_Z    = 3'd2,
      CSR_RIGHT_AXIS  = 3'd3,
      CSR_UP_AXIS     = 3'd4,
      CSR_FRAME_GROUP = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [TEX_W-1:0] u0;
      logic [TEX_W-1:0] v0;
   } cell_origin_type;

   localparam logic [4:0] FRAME_TABLE [GROUP_COUNT][8] = '{
      '{5'd0,  5'd1,  5'd2,  5'd3,  5'd4,  5'd5,  5'd6,  5'd7},
      '{5'd8,  5'd9,  5'd10, 5'd11, 5'd8,  5'd9,  5'd10, 5'd11},
      '{5'd12, 5'd12, 5'd12, 5'd12, 5'd12, 5'd12, 5'd12, 5'd12},
      '{5'd13, 5'd14, 5'd15, 5'd16, 5'd13, 5'd14, 5'd15, 5'd16},
      '{5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24}
   };

   localparam logic [2:0] CELL_COL [FRAME_COUNT] = '{
      3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
      3'd4, 3'd4, 3'd4, 3'd4, 3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd3
   };

   localparam logic [2:0] CELL_ROW [FRAME_COUNT] = '{
      3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd0,
      3'd1, 3'd2, 3'd3, 3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4
   };

   // atlas cell origin for a clamped group and a frame column
   function automatic cell_origin_type cell_origin(input logic [GROUP_W-1:0] grp,
                                                   input logic [2:0] col);
      logic [2:0] g;
      logic [4:0] frame;
      cell_origin_type res;
      g = (grp > GROUP_LAST) ? GROUP_LAST[2:0] : grp[2:0];
      if (g > GROUP_LAST[2:0]) begin
         g = GROUP_LAST[2:0];
      end
      frame  = FRAME_TABLE[g][col];
      res.u0 = TEX_W'(CELL_COL[frame]) * CELL_Q16;
      res.v0 = TEX_W'(CELL_ROW[frame]) * CELL_Q16;
      return res;
   endfunction

endpackage

@@ hdl/billboard_quad_expander.sv @@
// Billboard quad expander: one particle request in, four corner vertices out.
// A request passes the request register and the per-particle register; corner 0 is
// then loaded into the single corner output register, and corners 1..3 follow one
// per cycle when the result side keeps up, while stage 1 takes the next request.
// Reset (synchronous, active high) empties the pipeline, clears the corner counter
// and sets every configuration register to 0.
module billboard_quad_expander #(
   parameter int MAX_PARTICLES = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic        [bqe_pkg::IDX_W-1:0]      req_particle_index,
   input  logic signed [bqe_pkg::OFS_W-1:0]      req_offset_x,
   input  logic signed [bqe_pkg::OFS_W-1:0]      req_offset_y,
   input  logic signed [bqe_pkg::OFS_W-1:0]      req_offset_z,
   input  logic        [bqe_pkg::SIZE_W-1:0]     req_half_size,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic        [bqe_pkg::VTX_W-1:0]      rsp_vertex_number,
   output logic signed [bqe_pkg::POS_W-1:0]      rsp_pos_x,
   output logic signed [bqe_pkg::POS_W-1:0]      rsp_pos_y,
   output logic signed [bqe_pkg::POS_W-1:0]      rsp_pos_z,
   output logic        [bqe_pkg::TEX_W-1:0]      rsp_tex_u,
   output logic        [bqe_pkg::TEX_W-1:0]      rsp_tex_v,
   output logic                                 rsp_last_corner,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic        [bqe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [bqe_pkg::CSR_DATA_W-1:0] csr_data
);
   import bqe_pkg::*;

   // Index modulo MAX_PARTICLES by reciprocal multiply: the estimate is low by
   // at most one, so one compare and subtract fixes it.
   localparam int RECIP_SHIFT = 26;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int MAXP_W      = $clog2(MAX_PARTICLES + 1);
   localparam int QPROD_W     = IDX_W + RECIP_W;
   localparam int RPROD_W     = IDX_W + MAXP_W;
   localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'((2 ** RECIP_SHIFT) / MAX_PARTICLES);
   localparam logic [MAXP_W-1:0]  MAXP_C  = MAXP_W'(MAX_PARTICLES);

   localparam int PROD_W = COMP_W + SIZE_W + 1;   // signed axis times unsigned size
   localparam int FRAC_SHIFT = 14;                // Q1.14 * Q8.16 -> Q16.16

   // ---------------- configuration registers ----------------
   logic signed [POS_W-1:0]   camera_ff [3];
   logic        [AXIS_W-1:0]  right_axis_ff;
   logic        [AXIS_W-1:0]  up_axis_ff;
   logic        [GROUP_W-1:0] frame_group_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         camera_ff[0]   <= '0;
         camera_ff[1]   <= '0;
         camera_ff[2]   <= '0;
         right_axis_ff  <= '0;
         up_axis_ff     <= '0;
         frame_group_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CAMERA_X:    camera_ff[0]   <= POS_W'(csr_data);
            CSR_CAMERA_Y:    camera_ff[1]   <= POS_W'(csr_data);
            CSR_CAMERA_Z:    camera_ff[2]   <= POS_W'(csr_data);
            CSR_RIGHT_AXIS:  right_axis_ff  <= AXIS_W'(csr_data);
            CSR_UP_AXIS:     up_axis_ff     <= AXIS_W'(csr_data);
            CSR_FRAME_GROUP: frame_group_ff <= GROUP_W'(csr_data);
            default: begin
            end
         endcase
      end
   end

   // ---------------- handshake control ----------------
   logic                s1_valid_ff;
   logic                s2_valid_ff;
   logic                rsp_valid_ff;
   logic [CORNER_W-1:0] corner_ff;
   logic                out_load;
   logic                s2_done;
   logic                s2_load;
   logic                s1_load;

   assign out_load  = s2_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign s2_done   = out_load && (corner_ff == '1);
   assign s2_load   = s1_valid_ff && (!s2_valid_ff || s2_done);
   assign req_ready = !s1_valid_ff || s2_load;
   assign s1_load   = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         corner_ff    <= '0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= 1'b1;
         end else if (s2_load) begin
            s1_valid_ff <= 1'b0;
         end
         if (s2_load) begin
            s2_valid_ff <= 1'b1;
         end else if (s2_done) begin
            s2_valid_ff <= 1'b0;
         end
         if (out_load) begin
            corner_ff    <= corner_ff + CORNER_W'(1);
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------- stage 1: request register ----------------
   logic        [QPROD_W-1:0] quot_prod;
   logic        [IDX_W-1:0]   quot_in;
   logic        [IDX_W-1:0]   idx_ff;
   logic        [IDX_W-1:0]   quot_ff;
   logic signed [OFS_W-1:0]   ofs_ff [3];
   logic        [SIZE_W-1:0]  size_ff;

   assign quot_prod = QPROD_W'(req_particle_index) * QPROD_W'(RECIP_C);
   assign quot_in   = IDX_W'(quot_prod >> RECIP_SHIFT);

   always_ff @(posedge clock) begin
      if (s1_load) begin
         idx_ff    <= req_particle_index;
         quot_ff   <= quot_in;
         ofs_ff[0] <= req_offset_x;
         ofs_ff[1] <= req_offset_y;
         ofs_ff[2] <= req_offset_z;
         size_ff   <= req_half_size;
      end
   end

   // ---------------- stage 2: per-particle terms ----------------
   // axis component times half size, arithmetic shift to Q16.16
   function automatic logic signed [POS_W-1:0] scale(input logic [COMP_W-1:0] comp,
                                                     input logic [SIZE_W-1:0] size);
      logic signed [PROD_W-1:0] prod;
      prod = $signed({{(SIZE_W + 1){comp[COMP_W-1]}}, comp}) *
             $signed({{COMP_W{1'b0}}, 1'b0, size});
      return POS_W'(prod >>> FRAC_SHIFT);
   endfunction

   logic [RPROD_W-1:0]        rem_prod;
   logic [IDX_W-1:0]          rem_raw;
   logic [IDX_W-1:0]          idx_mod;
   logic signed [POS_W-1:0]   ctr_in [3];
   logic signed [POS_W-1:0]   dr_in  [3];
   logic signed [POS_W-1:0]   du_in  [3];
   cell_origin_type           cell_in;

   assign rem_prod = RPROD_W'(quot_ff) * RPROD_W'(MAXP_C);
   assign rem_raw  = IDX_W'(RPROD_W'(idx_ff) - rem_prod);
   assign idx_mod  = (RPROD_W'(rem_raw) >= RPROD_W'(MAXP_C)) ?
                     rem_raw - IDX_W'(MAXP_C) : rem_raw;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ctr_in[k] = camera_ff[k] + POS_W'(ofs_ff[k]);
         dr_in[k]  = scale(right_axis_ff[k*COMP_W +: COMP_W], size_ff);
         du_in[k]  = scale(up_axis_ff[k*COMP_W +: COMP_W], size_ff);
      end
   end

   // frame column is the low three bits of the reduced index
   assign cell_in = cell_origin(frame_group_ff, idx_mod[2:0]);

   logic        [IDX_W-1:0] s2_idx_ff;
   logic signed [POS_W-1:0] ctr_ff [3];
   logic signed [POS_W-1:0] dr_ff  [3];
   logic signed [POS_W-1:0] du_ff  [3];
   cell_origin_type         cell_ff;

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_idx_ff <= idx_mod;
         ctr_ff    <= ctr_in;
         dr_ff     <= dr_in;
         du_ff     <= du_in;
         cell_ff   <= cell_in;
      end
   end

   // ---------------- stage 3: corner output register ----------------
   // corner bit 1 picks +right, bit 0 picks +up
   logic                    plus_r;
   logic                    plus_u;
   logic signed [POS_W-1:0] pos_in [3];

   assign plus_r = corner_ff[1];
   assign plus_u = corner_ff[0];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pos_in[k] = ctr_ff[k] + (plus_r ? dr_ff[k] : -dr_ff[k])
                               + (plus_u ? du_ff[k] : -du_ff[k]);
      end
   end

   logic        [VTX_W-1:0] vertex_ff;
   logic signed [POS_W-1:0] pos_ff [3];
   logic        [TEX_W-1:0] tex_u_ff;
   logic        [TEX_W-1:0] tex_v_ff;
   logic                    last_ff;

   always_ff @(posedge clock) begin
      if (out_load) begin
         vertex_ff <= VTX_W'({s2_idx_ff, corner_ff});
         pos_ff    <= pos_in;
         tex_u_ff  <= plus_r ? cell_ff.u0 + CELL_Q16 : cell_ff.u0;
         tex_v_ff  <= plus_u ? cell_ff.v0 + CELL_Q16 : cell_ff.v0;
         last_ff   <= (corner_ff == '1);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_vertex_number = vertex_ff;
   assign rsp_pos_x         = pos_ff[0];
   assign rsp_pos_y         = pos_ff[1];
   assign rsp_pos_z         = pos_ff[2];
   assign rsp_tex_u         = tex_u_ff;
   assign rsp_tex_v         = tex_v_ff;
   assign rsp_last_corner   = last_ff;

endmodule
